// File: design/sakf_pkg.sv
// Shared types, constants and the microcode program of the scalar adaptive Kalman filter.
// Used by sakf_seq and scalar_adaptive_kalman_filter_unit.
package sakf_pkg;

  // Field widths
  localparam int EST_W   = 24;  // estimate and sample, Q16.8
  localparam int VAR_W   = 32;  // variances, Q8.24
  localparam int SPD_W   = 25;  // speed factor, Q1.24
  localparam int CFG_IDX_W = 2;
  localparam int PC_W    = 4;

  // Register reset values
  localparam logic [VAR_W-1:0] MEASURE_VAR_RST = 32'd671088640;  // 40.0
  localparam logic [VAR_W-1:0] INIT_VAR_RST    = 32'd3355443;    // about 0.2
  localparam logic [SPD_W-1:0] SPEED_RST       = 25'd16777;      // about 0.001

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_VAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd2;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_WAIT      = 4'd0;  // take the next sample
  localparam op_t OP_DIV_INIT  = 4'd1;  // form variance sum, seed divider
  localparam op_t OP_DIV_STEP  = 4'd2;  // one quotient bit of the gain
  localparam op_t OP_MUL_DIFF  = 4'd3;  // gain * (sample - estimate)
  localparam op_t OP_CHANGE    = 4'd4;  // scale change, move estimate
  localparam op_t OP_MUL_VAR   = 4'd5;  // (1 - gain) * variance
  localparam op_t OP_TERM1     = 4'd6;  // scale first variance term
  localparam op_t OP_MUL_SPEED = 4'd7;  // |change| * speed factor
  localparam op_t OP_UPDATE    = 4'd8;  // new variance, present result

  // Sequencing codes
  typedef logic [2:0] nxt_t;
  localparam nxt_t NXT_SEQ        = 3'd0;  // fall through
  localparam nxt_t NXT_JUMP       = 3'd1;  // unconditional jump
  localparam nxt_t NXT_WAIT_IN    = 3'd2;  // hold until an input transfer
  localparam nxt_t NXT_IF_SPECIAL = 3'd3;  // jump when the divide is trivial
  localparam nxt_t NXT_UNTIL_DONE = 3'd4;  // jump back until the count ends
  localparam nxt_t NXT_WAIT_OUT   = 3'd5;  // hold while the result slot is full, then jump

  typedef struct packed {
    op_t             op;
    nxt_t            nxt;
    logic [PC_W-1:0] target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_go;     // input transfer this cycle
    logic special;   // measurement variance is zero: gain known without dividing
    logic out_busy;  // result slot still held by the consumer
  } stat_t;

  // Microcode program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_WAIT,      nxt: NXT_WAIT_IN,    target: 4'd0};
      4'd1:    w = '{op: OP_DIV_INIT,  nxt: NXT_IF_SPECIAL, target: 4'd3};
      4'd2:    w = '{op: OP_DIV_STEP,  nxt: NXT_UNTIL_DONE, target: 4'd2};
      4'd3:    w = '{op: OP_MUL_DIFF,  nxt: NXT_SEQ,        target: 4'd0};
      4'd4:    w = '{op: OP_CHANGE,    nxt: NXT_SEQ,        target: 4'd0};
      4'd5:    w = '{op: OP_MUL_VAR,   nxt: NXT_SEQ,        target: 4'd0};
      4'd6:    w = '{op: OP_TERM1,     nxt: NXT_SEQ,        target: 4'd0};
      4'd7:    w = '{op: OP_MUL_SPEED, nxt: NXT_SEQ,        target: 4'd0};
      4'd8:    w = '{op: OP_UPDATE,    nxt: NXT_WAIT_OUT,   target: 4'd0};
      default: w = '{op: OP_WAIT,      nxt: NXT_JUMP,       target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

// File: design/sakf_seq.sv
// Microcode sequencer: step counter, program table and loop counter for the divider.
// Depends on sakf_pkg.
module sakf_seq #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  sakf_pkg::stat_t stat,
  output sakf_pkg::op_t   op
);
  import sakf_pkg::*;

  localparam int CW = $clog2(GAIN_FRAC_BITS);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [CW-1:0]   cnt;
  uword_t          uw;
  logic            done;

  assign uw   = ucode(pc);
  assign op   = uw.op;
  assign done = (cnt == CW'(GAIN_FRAC_BITS - 1));

  // Next step selection
  always_comb begin
    pc_next = pc + 1'b1;
    unique case (uw.nxt)
      NXT_SEQ:        pc_next = pc + 1'b1;
      NXT_JUMP:       pc_next = uw.target;
      NXT_WAIT_IN:    if (!stat.in_go) pc_next = pc;
      NXT_IF_SPECIAL: if (stat.special) pc_next = uw.target;
      NXT_UNTIL_DONE: if (!done) pc_next = uw.target;
      NXT_WAIT_OUT:   pc_next = stat.out_busy ? pc : uw.target;
      default:        pc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      cnt <= '0;
    end else begin
      pc <= pc_next;
      // count divider iterations, cleared outside the loop
      if (uw.op == OP_DIV_STEP) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

endmodule

// File: design/scalar_adaptive_kalman_filter_unit.sv
// Scalar adaptive Kalman filter: one Q16.8 sample in, one smoothed estimate out.
// out_valid rises after the input transfer once the divider steps (skipped when the measurement
// variance is zero) and the multiply steps are done. The next sample can be taken from the cycle
// after the result is registered, so a sample is not accepted while the one before is in work,
// and a stalled result slot holds off the update and with it the next sample. The restoring
// divider yields one gain bit per cycle. Synchronous reset clears the estimate, loads the
// variance with the initial_variance reset value and returns registers to defaults.
module scalar_adaptive_kalman_filter_unit #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sakf_pkg::EST_W-1:0]          sample,
  input  logic                                restart,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sakf_pkg::EST_W-1:0]          estimate,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sakf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sakf_pkg::VAR_W-1:0]          cfg_data
);
  import sakf_pkg::*;

  localparam int G  = GAIN_FRAC_BITS;
  localparam int GW = G + 1;                        // gain holds up to 1.0
  localparam int AW = (G + 2 > 26) ? G + 2 : 26;    // signed multiplier operand A
  localparam int PW = AW + VAR_W + 1;               // product width
  localparam logic [GW-1:0] ONE = {1'b1, {G{1'b0}}};

  // Configuration registers
  logic [VAR_W-1:0] measure_var;
  logic [SPD_W-1:0] speed;

  // Filter state and working registers
  logic [EST_W-1:0]     est;
  logic [VAR_W-1:0]     ev;
  logic [EST_W-1:0]     sample_r;
  logic [VAR_W:0]       sum_r;
  logic [VAR_W:0]       rem;
  logic [GW-1:0]        gain;
  logic signed [PW-1:0] prod;
  logic signed [EST_W:0] change;
  logic [VAR_W-1:0]     term1;

  op_t   op;
  stat_t stat;
  logic  in_go;
  logic  out_busy;
  logic  commit;

  // Combinational datapath
  logic signed [EST_W:0] diff;
  logic signed [EST_W:0] change_next;
  logic signed [EST_W:0] neg_change;
  logic [EST_W-1:0]      mag;
  logic [GW-1:0]         one_minus;
  logic [VAR_W+1:0]      rem_sh;
  logic [VAR_W+1:0]      rem_sub;
  logic                  fits;
  logic signed [AW-1:0]  mul_a;
  logic signed [VAR_W:0] mul_b;
  logic signed [PW-1:0]  product;
  logic signed [EST_W:0] est_sum;
  logic [40:0]           spd_term;
  logic [41:0]           nv_sum;
  logic [VAR_W-1:0]      nv_sat;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (op != OP_WAIT);
  assign in_go     = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;
  assign commit    = (op == OP_UPDATE) && !out_busy;

  assign stat = '{in_go: in_go, special: (measure_var == '0), out_busy: out_busy};

  sakf_seq #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .op   (op)
  );

  assign diff       = $signed({1'b0, sample_r}) - $signed({1'b0, est});
  assign neg_change = -change;
  assign mag        = change[EST_W] ? neg_change[EST_W-1:0] : change[EST_W-1:0];
  assign one_minus  = ONE - gain;

  // Restoring divider step
  assign rem_sh  = {rem, 1'b0};
  assign fits    = (rem_sh >= {1'b0, sum_r});
  assign rem_sub = rem_sh - {1'b0, sum_r};

  // Shared multiplier operand select
  always_comb begin
    unique case (op)
      OP_MUL_DIFF: begin
        mul_a = AW'(diff);
        mul_b = $signed((VAR_W + 1)'(gain));
      end
      OP_MUL_VAR: begin
        mul_a = $signed(AW'(one_minus));
        mul_b = $signed({1'b0, ev});
      end
      OP_MUL_SPEED: begin
        mul_a = $signed(AW'(mag));
        mul_b = $signed((VAR_W + 1)'(speed));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // arithmetic shift gives the floor of the scaled change
  assign change_next = (EST_W + 1)'(prod >>> G);

  // Estimate and variance update
  assign est_sum  = $signed({1'b0, est}) + change_next;
  assign spd_term = prod[48:8];
  assign nv_sum   = 42'(term1) + 42'(spd_term);
  assign nv_sat   = (|nv_sum[41:VAR_W]) ? '1 : nv_sum[VAR_W-1:0];

  // Control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_var <= MEASURE_VAR_RST;
      speed       <= SPEED_RST;
      est         <= '0;
      ev          <= INIT_VAR_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MEASURE_VAR: measure_var <= cfg_data;
          REG_INIT_VAR:    ;  // loaded only at reset, which restores its default
          REG_SPEED:       speed       <= cfg_data[SPD_W-1:0];
          default:         ;
        endcase
      end

      if (in_go && restart) est <= '0;
      else if (op == OP_CHANGE) est <= est_sum[EST_W-1:0];

      if (commit) ev <= nv_sat;

      // result slot
      if (commit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_go) sample_r <= sample;

    if (op == OP_DIV_INIT) begin
      sum_r <= (VAR_W + 1)'(ev) + (VAR_W + 1)'(measure_var);
      rem   <= (VAR_W + 1)'(ev);
      // zero measurement variance: gain is 1, or 0 when the variance is zero too
      if (stat.special) gain <= (ev == '0) ? '0 : ONE;
      else gain <= '0;
    end else if (op == OP_DIV_STEP) begin
      if (fits) rem <= rem_sub[VAR_W:0];
      else rem <= rem_sh[VAR_W:0];
      gain <= {gain[GW-2:0], fits};
    end

    if (op == OP_MUL_DIFF || op == OP_MUL_VAR || op == OP_MUL_SPEED) prod <= product;

    if (op == OP_CHANGE) change <= change_next;
    if (op == OP_TERM1) term1 <= prod[G+VAR_W-1:G];

    if (commit) estimate <= est;
  end

endmodule

// File: tb/sakf_checker.sv
// Checker for the scalar adaptive Kalman filter: watches the sample, estimate and
// register write channels, predicts each estimate and compares it on transfer.
// Depends on sakf_pkg for field widths, register indexes and reset values.
module sakf_checker #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [sakf_pkg::EST_W-1:0]       sample,
  input  logic                             restart,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [sakf_pkg::EST_W-1:0]       estimate,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sakf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sakf_pkg::VAR_W-1:0]       cfg_data,
  input  logic                             check_end,
  output int                               mismatches,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sakf_pkg::*;

  typedef logic [EST_W-1:0] est_t;

  localparam longint UNITY    = longint'(1) << GAIN_FRAC_BITS;
  localparam longint EST_CEIL = (longint'(1) << EST_W) - 1;
  localparam longint VAR_CEIL = (longint'(1) << VAR_W) - 1;

  // Shadow registers and filter state
  logic [VAR_W-1:0] meas_var;
  logic [SPD_W-1:0] speed;
  logic [VAR_W-1:0] variance;
  est_t             filt_est;

  est_t est_queue[$];
  est_t want;
  bit   leftover_checked;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  // One filter step: gain, estimate move, variance update with saturation
  function automatic est_t kalman_update(input est_t meas, input logic restart_est);
    longint ev, vsum, gain, m, e, diff, change, nxt, mag, new_var;
    if (restart_est) filt_est = '0;
    ev   = variance;
    vsum = ev + meas_var;
    gain = (vsum == 0) ? 0 : (ev << GAIN_FRAC_BITS) / vsum;
    if (gain > UNITY) gain = UNITY;
    m = meas;
    e = filt_est;
    diff   = m - e;
    change = (gain * diff) >>> GAIN_FRAC_BITS;  // floor toward negative infinity
    nxt    = e + change;
    if (nxt < 0) nxt = 0;
    if (nxt > EST_CEIL) nxt = EST_CEIL;
    mag     = (change < 0) ? -change : change;
    new_var = (((UNITY - gain) * ev) >> GAIN_FRAC_BITS) + ((mag * speed) >> 8);
    if (new_var > VAR_CEIL) new_var = VAR_CEIL;
    variance = new_var[VAR_W-1:0];
    filt_est = nxt[EST_W-1:0];
    return filt_est;
  endfunction

  // Transfers are sampled at the rising edge, before the inputs are updated
  always @(posedge clk) begin
    if (rst) begin
      meas_var = MEASURE_VAR_RST;
      speed    = SPEED_RST;
      variance = INIT_VAR_RST;
      filt_est = '0;
      est_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEASURE_VAR: meas_var = cfg_data;
          REG_INIT_VAR:    ;  // only takes effect at reset, which restores its default
          REG_SPEED:       speed = cfg_data[SPD_W-1:0];
          default: ;
        endcase
      end
      // compare first, so a result can never match a sample taken on the same edge
      if (out_valid && !out_stall) begin
        if (est_queue.size() == 0) begin
          report_mismatch($sformatf("estimate %h arrived with none pending", estimate));
        end else begin
          want = est_queue.pop_front();
          if (estimate !== want)
            report_mismatch($sformatf("estimate %h, predicted %h", estimate, want));
        end
      end
      if (in_valid && !in_stall) est_queue.push_back(kalman_update(sample, restart));
      if (check_end && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (est_queue.size() != 0)
          report_mismatch($sformatf("%0d estimates never arrived", est_queue.size()));
      end
    end
    pending = est_queue.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top for scalar_adaptive_kalman_filter_unit: clock, reset, sample stimulus,
// register writes, output stalls, watchdog and the final verdict.
// Depends on sakf_pkg and sakf_checker, which does all prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sakf_pkg::*;

  typedef logic [EST_W-1:0] est_t;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int LATENCY        = GAIN_FRAC_BITS + 8;
  localparam int SETTLE         = LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index, write is dropped
  localparam logic [VAR_W-1:0] VAR_MAX   = 32'hFFFF_FFFF;
  localparam logic [VAR_W-1:0] SPEED_MAX = 32'd16777216;  // 1.0
  localparam est_t EST_MAX = 24'hFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  est_t                 sample = '0;
  logic                 restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  est_t                 estimate;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAR_W-1:0]     cfg_data = '0;
  logic                 check_end = 1'b0;

  int   mismatches;
  int   pending;
  int   idle_count = 0;
  int   stall_hold = 0;
  int   stall_pick;
  bit   quiet = 1'b0;  // no gaps and no stalls while set
  est_t last_sample = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  scalar_adaptive_kalman_filter_unit #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall), .estimate(estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sakf_checker #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall), .estimate(estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .check_end(check_end),
    .mismatches(mismatches), .pending(pending)
  );

  // Output stalls: mostly short runs, now and then a long one, with stall-free stretches
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 30);
      end else if (stall_pick < 92) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 80);
      end
    end
  end

  // Watchdog: cycles in which no transfer happens on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
  end

  initial begin
    while (idle_count < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Extremes, small steps around the last sample, or anything
  function automatic est_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return EST_MAX;
      2, 3, 4: return est_t'(last_sample + $urandom_range(0, 511) - 256);
      default: return est_t'($urandom);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_item(input est_t s, input logic r);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= r;
    do @(posedge clk); while (in_stall);
    last_sample = s;
  endtask

  // Hold off the sender until every predicted estimate has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      send_item(pick_sample(), $urandom_range(0, 11) == 0);
      if ($urandom_range(0, 149) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: slow gain, field extremes, restart from both ends
    send_item('0, 1'b0);
    send_item(EST_MAX, 1'b0);
    send_item(EST_MAX, 1'b0);
    send_item('0, 1'b1);
    send_item(EST_MAX, 1'b1);
    send_item(24'h80_0000, 1'b0);
    send_item('0, 1'b0);
    run_random(200);

    // Zero measurement variance: gain of one, estimate jumps, variance saturates
    write_reg(REG_MEASURE_VAR, '0);
    write_reg(REG_SPEED, SPEED_MAX);
    quiet = 1'b1;
    send_item(24'h12_3456, 1'b0);
    send_item('0, 1'b0);
    send_item(EST_MAX, 1'b0);
    send_item(EST_MAX, 1'b1);
    run_random(200);
    quiet = 1'b0;

    // Largest measurement variance: variance sum needs the 33rd bit
    write_reg(REG_MEASURE_VAR, VAR_MAX);
    write_reg(REG_INIT_VAR, VAR_MAX);
    write_reg(REG_NONE, $urandom);
    write_reg(REG_SPEED, $urandom_range(0, SPEED_MAX));
    send_item('0, 1'b0);
    send_item(EST_MAX, 1'b0);
    run_random(200);

    // Smallest nonzero measurement variance
    write_reg(REG_MEASURE_VAR, 32'd1);
    write_reg(REG_SPEED, SPEED_MAX);
    write_reg(REG_INIT_VAR, '0);
    run_random(200);

    // Random settings
    repeat (2) begin
      write_reg(REG_MEASURE_VAR, $urandom);
      write_reg(REG_SPEED, $urandom_range(0, SPEED_MAX));
      write_reg(REG_INIT_VAR, $urandom);
      write_reg(REG_NONE, $urandom);
      run_random(100);
    end

    // Zero variance sum last: once the variance reaches zero it stays there
    write_reg(REG_MEASURE_VAR, '0);
    write_reg(REG_SPEED, '0);
    send_item(24'hAB_CDEF, 1'b0);
    send_item('0, 1'b0);
    send_item(EST_MAX, 1'b0);
    send_item(EST_MAX, 1'b1);
    send_item(24'h00_0100, 1'b0);
    drain();

    repeat (SETTLE) @(posedge clk);
    check_end <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
design/sakf_pkg.sv
design/sakf_seq.sv
design/scalar_adaptive_kalman_filter_unit.sv
tb/sakf_checker.sv
tb/tb.sv
